### rtl/core/assert_macros.svh
// Shared assertion macros for the terminal core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define TCW_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tcw assertion failed");

// Boolean condition must never be true outside reset.
`define TCW_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("tcw forbidden condition seen");

`endif

### rtl/core/tcw_pkg.sv
`timescale 1ns / 1ps
package tcw_pkg;

  localparam int COLS   = 80;
  localparam int ROWS   = 25;
  localparam int NCELLS = COLS * ROWS;

  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CELL_W = $clog2(NCELLS);
  localparam int CHAR_W = 8;
  localparam int CLR_W  = 4;
  localparam int DATA_W = CHAR_W + 2 * CLR_W;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic CFG_FG = 1'b0;
  localparam logic CFG_BG = 1'b1;

  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TILDE   = 8'h7E;
  localparam logic [CHAR_W-1:0] CH_DEL     = 8'h7F;
  localparam logic [CHAR_W-1:0] CH_ESC     = 8'h1B;
  localparam logic [CHAR_W-1:0] CH_BS      = 8'h08;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SAVE    = 8'h37;
  localparam logic [CHAR_W-1:0] CH_RESTORE = 8'h38;

  localparam logic [CLR_W-1:0] FG_RESET = 4'd15;
  localparam logic [CLR_W-1:0] BG_RESET = 4'd0;
  localparam logic [DATA_W-1:0] BLANK_RESET = {BG_RESET, FG_RESET, CH_SPACE};

  typedef struct packed {
    logic ld_item;
    logic exec;
    logic access;
    logic scroll_wr;
    logic init_wr;
    logic out_load;
  } tcw_cmd_t;

  typedef struct packed {
    logic init_last;
    logic row_last;
    logic scroll_pend;
  } tcw_stat_t;

endpackage

### rtl/core/tcw_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tcw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  tcw_pkg::tcw_stat_t stat_i,
  output tcw_pkg::tcw_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_ACCESS,
    S_SCROLL,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.init_wr = 1'b1;
        if (stat_i.init_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.ld_item = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.exec = 1'b1;
        state_d    = S_ACCESS;
      end
      S_ACCESS: begin
        cmd_o.access = 1'b1;
        state_d      = stat_i.scroll_pend ? S_SCROLL : S_DONE;
      end
      S_SCROLL: begin
        cmd_o.scroll_wr = 1'b1;
        if (stat_i.row_last) state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    out_valid_d = cmd_o.out_load | (out_valid_q & out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  `TCW_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, cmd_o.out_load && out_valid_q && out_stall_i)
  `TCW_ASSERT(a_scroll_exit, clk_i, rst_ni, (state_q == S_SCROLL) |=> (state_q == S_SCROLL || state_q == S_DONE))

endmodule

### rtl/core/tcw_dp.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tcw_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tcw_pkg::tcw_cmd_t                 cmd_i,
  output tcw_pkg::tcw_stat_t                stat_o,
  input  logic [tcw_pkg::CLR_W-1:0]         fg_i,
  input  logic [tcw_pkg::CLR_W-1:0]         bg_i,
  input  logic                              item_op_i,
  input  logic [tcw_pkg::CHAR_W-1:0]        char_byte_i,
  input  logic [tcw_pkg::CELL_W-1:0]        cell_addr_i,
  output logic [tcw_pkg::ROW_W-1:0]         pos_row_o,
  output logic [tcw_pkg::COL_W-1:0]         pos_col_o,
  output logic                              esc_pending_o,
  output logic [tcw_pkg::CHAR_W-1:0]        cell_char_o,
  output logic [tcw_pkg::CLR_W-1:0]         cell_fg_o,
  output logic [tcw_pkg::CLR_W-1:0]         cell_bg_o
);

  localparam logic [tcw_pkg::ROW_W-1:0]  ROW_LAST  = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
  localparam logic [tcw_pkg::COL_W-1:0]  COL_LAST  = tcw_pkg::COL_W'(tcw_pkg::COLS - 1);
  localparam logic [tcw_pkg::CELL_W-1:0] CELL_LAST = tcw_pkg::CELL_W'(tcw_pkg::NCELLS - 1);
  localparam logic [tcw_pkg::CELL_W-1:0] CELL_CNT  = tcw_pkg::CELL_W'(tcw_pkg::NCELLS);
  localparam logic [tcw_pkg::CELL_W-1:0] LINE_CNT  = tcw_pkg::CELL_W'(tcw_pkg::COLS);
  localparam logic [tcw_pkg::CELL_W-1:0] BASE_LAST =
    tcw_pkg::CELL_W'(tcw_pkg::NCELLS - tcw_pkg::COLS);
  localparam logic [tcw_pkg::CELL_W:0]   CELL_CNT_X = (tcw_pkg::CELL_W + 1)'(tcw_pkg::NCELLS);

  logic                          item_cmd_q;
  logic [tcw_pkg::CHAR_W-1:0]    item_char_q;
  logic [tcw_pkg::CELL_W-1:0]    item_addr_q;

  logic [tcw_pkg::ROW_W-1:0]     row_q, row_d, srow_q, srow_d, wrow;
  logic [tcw_pkg::COL_W-1:0]     col_q, col_d, scol_q, scol_d, wcol;
  logic                          esc_q, esc_d;
  logic                          moved;

  logic                          wr_pend_q, wr_pend_d;
  logic                          rd_pend_q, rd_pend_d;
  logic                          scroll_pend_q, scroll_pend_d;
  logic [tcw_pkg::CELL_W-1:0]    lidx_q, lidx_d;
  logic [tcw_pkg::CHAR_W-1:0]    wchar_q, wchar_d;

  logic [tcw_pkg::CELL_W-1:0]    base_q;
  logic [tcw_pkg::CELL_W-1:0]    cnt_q;
  logic [tcw_pkg::CELL_W:0]      phys_sum;
  logic [tcw_pkg::CELL_W-1:0]    phys;

  logic                          mem_we, mem_re;
  logic [tcw_pkg::CELL_W-1:0]    waddr;
  logic [tcw_pkg::DATA_W-1:0]    wdata;
  logic [tcw_pkg::DATA_W-1:0]    cells_mem [tcw_pkg::NCELLS];
  logic [tcw_pkg::DATA_W-1:0]    rdata_q;

  logic [tcw_pkg::ROW_W-1:0]     out_row_q;
  logic [tcw_pkg::COL_W-1:0]     out_col_q;
  logic                          out_esc_q;
  logic [tcw_pkg::DATA_W-1:0]    out_cell_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_item) begin
      item_cmd_q  <= item_op_i;
      item_char_q <= char_byte_i;
      item_addr_q <= cell_addr_i;
    end
  end

  always_comb begin
    row_d         = row_q;
    col_d         = col_q;
    srow_d        = srow_q;
    scol_d        = scol_q;
    esc_d         = esc_q;
    wr_pend_d     = 1'b0;
    rd_pend_d     = 1'b0;
    scroll_pend_d = 1'b0;
    wrow          = row_q;
    wcol          = col_q;
    wchar_d       = item_char_q;
    moved         = 1'b0;
    if (item_cmd_q == tcw_pkg::CMD_READ) begin
      rd_pend_d = (item_addr_q < CELL_CNT);
    end else if (esc_q) begin
      esc_d = 1'b0;
      if (item_char_q == tcw_pkg::CH_SAVE) begin
        srow_d = row_q;
        scol_d = col_q;
      end else if (item_char_q == tcw_pkg::CH_RESTORE) begin
        row_d = srow_q;
        col_d = scol_q;
      end
    end else begin
      unique case (item_char_q) inside
        tcw_pkg::CH_ESC: begin
          esc_d = 1'b1;
        end
        tcw_pkg::CH_DEL, tcw_pkg::CH_BS: begin
          if (col_q != '0) begin
            col_d = col_q - 1'b1;
            moved = 1'b1;
          end else if (row_q != '0) begin
            row_d = row_q - 1'b1;
            col_d = COL_LAST;
            moved = 1'b1;
          end
          wr_pend_d = moved && (item_char_q == tcw_pkg::CH_DEL);
          wrow      = row_d;
          wcol      = col_d;
          wchar_d   = tcw_pkg::CH_SPACE;
        end
        tcw_pkg::CH_CR: begin
          col_d = '0;
        end
        tcw_pkg::CH_LF: begin
          col_d = '0;
          if (row_q == ROW_LAST) scroll_pend_d = 1'b1;
          else row_d = row_q + 1'b1;
        end
        [tcw_pkg::CH_SPACE:tcw_pkg::CH_TILDE]: begin
          wr_pend_d = 1'b1;
          if (col_q == COL_LAST) begin
            col_d = '0;
            if (row_q == ROW_LAST) scroll_pend_d = 1'b1;
            else row_d = row_q + 1'b1;
          end else begin
            col_d = col_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (item_cmd_q == tcw_pkg::CMD_READ) begin
      lidx_d = item_addr_q;
    end else begin
      lidx_d = tcw_pkg::CELL_W'(wrow) * LINE_CNT + tcw_pkg::CELL_W'(wcol);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q         <= '0;
      col_q         <= '0;
      srow_q        <= '0;
      scol_q        <= '0;
      esc_q         <= 1'b0;
      wr_pend_q     <= 1'b0;
      rd_pend_q     <= 1'b0;
      scroll_pend_q <= 1'b0;
    end else if (cmd_i.exec) begin
      row_q         <= row_d;
      col_q         <= col_d;
      srow_q        <= srow_d;
      scol_q        <= scol_d;
      esc_q         <= esc_d;
      wr_pend_q     <= wr_pend_d;
      rd_pend_q     <= rd_pend_d;
      scroll_pend_q <= scroll_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      lidx_q  <= lidx_d;
      wchar_q <= wchar_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.init_wr) begin
      cnt_q <= stat_o.init_last ? '0 : cnt_q + 1'b1;
    end else if (cmd_i.scroll_wr) begin
      cnt_q <= stat_o.row_last ? '0 : cnt_q + 1'b1;
      if (stat_o.row_last) begin
        base_q <= (base_q == BASE_LAST) ? '0 : base_q + LINE_CNT;
      end
    end
  end

  assign stat_o.init_last   = (cnt_q == CELL_LAST);
  assign stat_o.row_last    = (cnt_q == LINE_CNT - 1'b1);
  assign stat_o.scroll_pend = scroll_pend_q;

  assign phys_sum = {1'b0, lidx_q} + {1'b0, base_q};

  always_comb begin
    if (phys_sum >= CELL_CNT_X) phys = tcw_pkg::CELL_W'(phys_sum - CELL_CNT_X);
    else phys = phys_sum[tcw_pkg::CELL_W-1:0];
  end

  always_comb begin
    mem_we = 1'b0;
    waddr  = phys;
    wdata  = {bg_i, fg_i, wchar_q};
    if (cmd_i.init_wr) begin
      mem_we = 1'b1;
      waddr  = cnt_q;
      wdata  = tcw_pkg::BLANK_RESET;
    end else if (cmd_i.scroll_wr) begin
      mem_we = 1'b1;
      waddr  = base_q + cnt_q;
      wdata  = {bg_i, fg_i, tcw_pkg::CH_SPACE};
    end else if (cmd_i.access) begin
      mem_we = wr_pend_q;
    end
  end

  assign mem_re = cmd_i.access & rd_pend_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) cells_mem[waddr] <= wdata;
    if (mem_re) rdata_q <= cells_mem[phys];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_row_q  <= row_q;
      out_col_q  <= col_q;
      out_esc_q  <= esc_q;
      out_cell_q <= rd_pend_q ? rdata_q : '0;
    end
  end

  assign pos_row_o     = out_row_q;
  assign pos_col_o     = out_col_q;
  assign esc_pending_o = out_esc_q;
  assign cell_char_o   = out_cell_q[tcw_pkg::CHAR_W-1:0];
  assign cell_fg_o     = out_cell_q[tcw_pkg::CHAR_W+tcw_pkg::CLR_W-1:tcw_pkg::CHAR_W];
  assign cell_bg_o     = out_cell_q[tcw_pkg::DATA_W-1:tcw_pkg::CHAR_W+tcw_pkg::CLR_W];

  `TCW_ASSERT(a_cursor_range, clk_i, rst_ni, (row_q <= ROW_LAST) && (col_q <= COL_LAST))
  `TCW_ASSERT(a_waddr_range, clk_i, rst_ni, mem_we |-> (waddr < CELL_CNT))

endmodule

### rtl/core/text_console_writer.sv
`timescale 1ns / 1ps
// Text-mode terminal core holding an 80 x 25 screen of 16-bit cells (character, foreground,
// background) in one single-port memory. After reset a clearing pass writes every one of
// the 2000 cells to a blank with the reset colours, during which no item is accepted
// (colour registers may be written meanwhile). Each item then passes through item load,
// decode, memory access and result load. A byte that moves the cursor past the bottom row
// adds a pass that writes a blank to each cell of the new bottom line; the scroll itself
// only moves the top-of-screen offset in the memory. The result register lets a new
// item be taken while the previous result still waits.
module text_console_writer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tcw_pkg::PADDR_W-1:0]       paddr,
  input  logic [tcw_pkg::PDATA_W-1:0]       pwdata,
  output logic [tcw_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              cmd_i,
  input  logic [tcw_pkg::CHAR_W-1:0]        char_byte_i,
  input  logic [tcw_pkg::CELL_W-1:0]        cell_addr_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [tcw_pkg::ROW_W-1:0]         pos_row_o,
  output logic [tcw_pkg::COL_W-1:0]         pos_col_o,
  output logic                              esc_pending_o,
  output logic [tcw_pkg::CHAR_W-1:0]        cell_char_o,
  output logic [tcw_pkg::CLR_W-1:0]         cell_fg_o,
  output logic [tcw_pkg::CLR_W-1:0]         cell_bg_o
);

  logic [tcw_pkg::CLR_W-1:0] fg_q, bg_q;
  logic                      cfg_wr;
  tcw_pkg::tcw_cmd_t         cmd;
  tcw_pkg::tcw_stat_t        stat;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= tcw_pkg::FG_RESET;
      bg_q <= tcw_pkg::BG_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == tcw_pkg::CFG_FG) fg_q <= pwdata[tcw_pkg::CLR_W-1:0];
      else bg_q <= pwdata[tcw_pkg::CLR_W-1:0];
    end
  end

  assign prdata = (paddr[2] == tcw_pkg::CFG_BG) ?
                  tcw_pkg::PDATA_W'(bg_q) : tcw_pkg::PDATA_W'(fg_q);

  tcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  tcw_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .fg_i          (fg_q),
    .bg_i          (bg_q),
    .item_op_i     (cmd_i),
    .char_byte_i   (char_byte_i),
    .cell_addr_i   (cell_addr_i),
    .pos_row_o     (pos_row_o),
    .pos_col_o     (pos_col_o),
    .esc_pending_o (esc_pending_o),
    .cell_char_o   (cell_char_o),
    .cell_fg_o     (cell_fg_o),
    .cell_bg_o     (cell_bg_o)
  );

endmodule
